// ===== design/bptc_pkg.sv =====
// ----------------------------------------------------------------------------
// BPTC(196,96) decoder package
// Shared frame geometry, Hamming check tables and transaction types.
// ----------------------------------------------------------------------------
package bptc_pkg;

  localparam int FrameBits = 196;
  localparam int NCols     = 15;
  localparam int NRows     = 13;
  localparam int DataRows  = 9;
  localparam int RowData   = 11;
  localparam int DataBits  = 96;
  localparam int SynBits   = 4;

  // Hamming(13,9) column check pattern of each row position, MSB is b0.
  localparam logic [SynBits-1:0] ColTab [NRows] = '{
    4'hF, 4'hE, 4'h7, 4'hA, 4'h5, 4'hB, 4'hC, 4'h6, 4'h3,
    4'h8, 4'h4, 4'h2, 4'h1
  };

  // Hamming(15,11) row check pattern of each column position, MSB is b0.
  localparam logic [SynBits-1:0] RowTab [NCols] = '{
    4'h9, 4'hD, 4'hF, 4'hE, 4'h7, 4'hA, 4'h5, 4'hB, 4'hC, 4'h6, 4'h3,
    4'h8, 4'h4, 4'h2, 4'h1
  };

  typedef struct packed {
    logic [63:0] frame_low;
    logic [63:0] frame_mid;
    logic [63:0] frame_upper;
    logic [3:0]  frame_tail;
  } in_t;

  typedef struct packed {
    logic [63:0] fixed_low;
    logic [63:0] fixed_mid;
    logic [63:0] fixed_upper;
    logic [3:0]  fixed_tail;
    logic [47:0] payload_low;
    logic [47:0] payload_high;
    logic        repaired_ok;
    logic        errors_seen;
  } out_t;

  // Status that each decoding lane reports to the merge logic.
  typedef struct packed {
    logic err;   // nonzero syndrome
    logic bad;   // nonzero syndrome with no matching bit
  } lane_flags_t;

endpackage

// ===== design/bptc_196_96_decoder.sv =====
// An accepted frame goes through the stage 1 and stage 2 registers to the output.
// Throughput: one frame per cycle; the column stage and the row stage are registered
// stages, so a new frame enters every cycle unless the output is stalled.
// Reset clears both stage valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
// BPTC(196,96) decoder top level
// Fifteen column lanes repair the frame with Hamming(13,9), nine row lanes then
// repair the data rows with Hamming(15,11), and a merge stage extracts the
// 96 data bits and the status flags.
// ----------------------------------------------------------------------------
module bptc_196_96_decoder (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bptc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bptc_pkg::out_t  out_data_o
);

  // The frame is handled as one flat vector; matrix bit (r,c) sits at
  // index 1 + 15r + c and bit 0 is carried through untouched.
  logic [bptc_pkg::FrameBits-1:0] frame_in;
  logic [bptc_pkg::FrameBits-1:0] frame_col;
  logic [bptc_pkg::FrameBits-1:0] frame_row;

  logic [bptc_pkg::NRows-1:0] col_in    [bptc_pkg::NCols];
  logic [bptc_pkg::NRows-1:0] col_out   [bptc_pkg::NCols];
  bptc_pkg::lane_flags_t      col_flags [bptc_pkg::NCols];

  logic [bptc_pkg::NCols-1:0] row_in    [bptc_pkg::DataRows];
  logic [bptc_pkg::NCols-1:0] row_out   [bptc_pkg::DataRows];
  bptc_pkg::lane_flags_t      row_flags [bptc_pkg::DataRows];

  logic col_ok;
  logic col_seen;
  logic row_bad;
  logic row_seen;

  // Stage 1 holds the frame after the column repair, stage 2 the result.
  logic                           v1_q, v1_d;
  logic                           v2_q, v2_d;
  logic [bptc_pkg::FrameBits-1:0] frame1_q;
  logic                           ok1_q;
  logic                           seen1_q;
  bptc_pkg::out_t                 out_q, out_d;
  logic [bptc_pkg::DataBits-1:0]  data;

  logic ready1;
  logic ready2;

  assign frame_in = {in_data_i.frame_tail, in_data_i.frame_upper,
                     in_data_i.frame_mid, in_data_i.frame_low};

  // --------------------------------------------------------------------------
  // Column lanes: one Hamming(13,9) decoder per matrix column.
  // --------------------------------------------------------------------------
  assign frame_col[0] = frame_in[0];

  for (genvar c = 0; c < bptc_pkg::NCols; c++) begin : g_col
    for (genvar r = 0; r < bptc_pkg::NRows; r++) begin : g_bit
      assign col_in[c][r]             = frame_in[1 + 15 * r + c];
      assign frame_col[1 + 15 * r + c] = col_out[c][r];
    end

    bptc_col_lane u_col_lane (
      .col_i   (col_in[c]),
      .col_o   (col_out[c]),
      .flags_o (col_flags[c])
    );
  end

  // A column with an unmatched syndrome makes the whole frame uncorrectable.
  always_comb begin
    col_ok   = 1'b1;
    col_seen = 1'b0;
    for (int c = 0; c < bptc_pkg::NCols; c++) begin
      col_ok   = col_ok & ~col_flags[c].bad;
      col_seen = col_seen | col_flags[c].err;
    end
  end

  // --------------------------------------------------------------------------
  // Row lanes: the nine data rows get a Hamming(15,11) decoder each, working
  // on the column-repaired frame from stage 1. The parity rows pass through.
  // --------------------------------------------------------------------------
  assign frame_row[0] = frame1_q[0];

  for (genvar r = 0; r < bptc_pkg::NRows; r++) begin : g_row
    if (r < bptc_pkg::DataRows) begin : g_data
      for (genvar c = 0; c < bptc_pkg::NCols; c++) begin : g_bit
        assign row_in[r][c]              = frame1_q[1 + 15 * r + c];
        assign frame_row[1 + 15 * r + c] = row_out[r][c];
      end

      bptc_row_lane u_row_lane (
        .row_i   (row_in[r]),
        .row_o   (row_out[r]),
        .flags_o (row_flags[r])
      );
    end else begin : g_parity
      assign frame_row[1 + 15 * r + bptc_pkg::NCols - 1 : 1 + 15 * r] =
        frame1_q[1 + 15 * r + bptc_pkg::NCols - 1 : 1 + 15 * r];
    end
  end

  always_comb begin
    row_bad  = 1'b0;
    row_seen = 1'b0;
    for (int r = 0; r < bptc_pkg::DataRows; r++) begin
      row_bad  = row_bad | row_flags[r].bad;
      row_seen = row_seen | row_flags[r].err;
    end
  end

  // --------------------------------------------------------------------------
  // Merge: the payload is row 0 columns 3 to 10, then rows 1 to 8 columns
  // 0 to 10, taken from the fully repaired frame.
  // --------------------------------------------------------------------------
  for (genvar r = 0; r < bptc_pkg::DataRows; r++) begin : g_pay
    for (genvar c = 0; c < bptc_pkg::RowData; c++) begin : g_bit
      if (r == 0 && c >= 3) begin : g_first
        assign data[c - 3] = frame_row[1 + 15 * r + c];
      end else if (r > 0) begin : g_rest
        assign data[8 + 11 * (r - 1) + c] = frame_row[1 + 15 * r + c];
      end
    end
  end

  always_comb begin
    out_d.fixed_low    = frame_row[63:0];
    out_d.fixed_mid    = frame_row[127:64];
    out_d.fixed_upper  = frame_row[191:128];
    out_d.fixed_tail   = frame_row[195:192];
    out_d.payload_low  = data[47:0];
    out_d.payload_high = data[95:48];
    out_d.repaired_ok  = ok1_q & ~row_bad;
    out_d.errors_seen  = seen1_q | row_seen;
  end

  // --------------------------------------------------------------------------
  // Pipeline control. Each stage advances when it is empty or when the stage
  // after it advances, so a waiting result never blocks a new input frame
  // while stage 1 has room.
  // --------------------------------------------------------------------------
  always_comb begin
    ready2 = !v2_q || !out_stall_i;
    ready1 = !v1_q || ready2;
    v1_d   = ready1 ? in_valid_i : v1_q;
    v2_d   = ready2 ? v1_q : v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      frame1_q <= frame_col;
      ok1_q    <= col_ok;
      seen1_q  <= col_seen;
    end
    if (ready2) begin
      out_q <= out_d;
    end
  end

  assign in_stall_o  = !ready1;
  assign out_valid_o = v2_q;
  assign out_data_o  = out_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An uncorrectable frame must have shown a nonzero syndrome.
  a_ok_implies_seen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !ok1_q) |-> seen1_q)
    else $error("column stage flags a frame uncorrectable without any error");

  // The same holds at the output after the row stage merged its flags.
  a_out_ok_seen : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.repaired_ok) |-> out_data_o.errors_seen)
    else $error("result uncorrectable without errors_seen");

  // The first payload byte is row 0 columns 3 to 10, frame bits 4 to 11.
  a_payload_map : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.payload_low[7:0] == out_data_o.fixed_low[11:4]))
    else $error("payload does not match the repaired frame");

  // A full pipeline under output stall must push back on the input.
  a_full_stalls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted while both stages are held");

  // A frame waiting in stage 1 is not lost while the output is stalled.
  a_stage1_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && v2_q && out_stall_i) |=> (v1_q && $stable(frame1_q)))
    else $error("stage 1 frame lost under stall");

endmodule

// ===== design/bptc_col_lane.sv =====
// ----------------------------------------------------------------------------
// BPTC column lane
// Hamming(13,9) syndrome and single-bit repair of one matrix column.
// ----------------------------------------------------------------------------
module bptc_col_lane (
  input  logic [bptc_pkg::NRows-1:0] col_i,
  output logic [bptc_pkg::NRows-1:0] col_o,
  output bptc_pkg::lane_flags_t      flags_o
);

  logic [bptc_pkg::SynBits-1:0] syn;
  logic                         hit;

  always_comb begin
    syn = '0;
    for (int r = 0; r < bptc_pkg::NRows; r++) begin
      if (col_i[r]) begin
        syn = syn ^ bptc_pkg::ColTab[r];
      end
    end
    col_o = col_i;
    hit   = 1'b0;
    // All table entries differ, so at most one position can match.
    for (int k = 0; k < bptc_pkg::NRows; k++) begin
      if ((syn != '0) && (bptc_pkg::ColTab[k] == syn)) begin
        col_o[k] = ~col_i[k];
        hit      = 1'b1;
      end
    end
    flags_o.err = (syn != '0);
    flags_o.bad = (syn != '0) && !hit;
  end

endmodule

// ===== design/bptc_row_lane.sv =====
// ----------------------------------------------------------------------------
// BPTC row lane
// Hamming(15,11) syndrome and single-bit repair of one data row.
// ----------------------------------------------------------------------------
module bptc_row_lane (
  input  logic [bptc_pkg::NCols-1:0] row_i,
  output logic [bptc_pkg::NCols-1:0] row_o,
  output bptc_pkg::lane_flags_t      flags_o
);

  logic [bptc_pkg::SynBits-1:0] syn;
  logic                         hit;

  always_comb begin
    syn = '0;
    for (int c = 0; c < bptc_pkg::NCols; c++) begin
      if (row_i[c]) begin
        syn = syn ^ bptc_pkg::RowTab[c];
      end
    end
    row_o = row_i;
    hit   = 1'b0;
    for (int k = 0; k < bptc_pkg::NCols; k++) begin
      if ((syn != '0) && (bptc_pkg::RowTab[k] == syn)) begin
        row_o[k] = ~row_i[k];
        hit      = 1'b1;
      end
    end
    flags_o.err = (syn != '0);
    flags_o.bad = (syn != '0) && !hit;
  end

endmodule
